[rtl/assert_macros.svh]
// Assertion helpers used by weighted_delay_and_sum_stack.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/wdas_pkg.sv]
package wdas_pkg;

    // Field widths
    localparam int OP_W     = 2;
    localparam int SAMPLE_W = 24;
    localparam int WEIGHT_W = 16;
    localparam int START_W  = 24;
    localparam int INDEX_W  = 16;
    localparam int OPOS_W   = 12;
    localparam int OFFS_W   = 24;
    localparam int OLEN_W   = 13;
    localparam int ACC_W    = 48;
    localparam int PROD_W   = SAMPLE_W + WEIGHT_W;
    // Window position: start - offset + index, always fits in 26 signed bits
    localparam int POS_W    = 26;

    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 48;

    // Opcodes
    localparam logic [OP_W-1:0] OP_ACC    = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_REDUCE = 2'd2;

    // Register indexes
    localparam logic REG_WINDOW_OFFSET = 1'b0;
    localparam logic REG_OUT_LENGTH    = 1'b1;

    localparam logic [OLEN_W-1:0] OUT_LENGTH_RST = 13'd4096;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic signed [PROD_W-1:0] prod_t;

endpackage

[rtl/wdas_ram.sv]
module wdas_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port; read returns old data on collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/weighted_delay_and_sum_stack.sv]
// Accumulate and read words: one word per cycle in the run state unless a read result waits on a
//   full output register; stage-to-stage forwarding covers back-to-back hits on one entry.
// Reduce word: drains the two-stage pipe, then reads and clears one memory entry per cycle
//   over the window (out_length entries, capped at MAX_OUT_LEN), then emits the peak.
// Reset: async, active low; afterwards a clearing pass zeroes all MAX_OUT_LEN stack entries,
//   one per cycle, with s_tready low (config writes still taken).
`include "assert_macros.svh"

module weighted_delay_and_sum_stack #(
    parameter int MAX_OUT_LEN = 4096
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic                         s_tvalid,
    output logic                         s_tready,
    // sample_value[23:0], weight[39:24], trace_start[63:40], sample_index[79:64],
    // out_position[91:80], zero pad [95:92]
    input  logic [wdas_pkg::IN_DATA_W-1:0] s_tdata,
    // opcode[1:0]
    input  logic [wdas_pkg::OP_W-1:0]      s_tuser,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // result_value[47:0]
    output logic [wdas_pkg::OUT_DATA_W-1:0] m_tdata,
    // is_peak[0]
    output logic [0:0]                      m_tuser
);

    import wdas_pkg::*;

    localparam int AW    = $clog2(MAX_OUT_LEN);
    localparam int LEN_W = AW + 1;

    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    // Configuration registers
    logic signed [OFFS_W-1:0] window_offset_reg;
    logic [OLEN_W-1:0]        out_length_reg;
    logic                     cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_offset_reg <= '0;
            out_length_reg    <= OUT_LENGTH_RST;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_WINDOW_OFFSET)
            begin
                window_offset_reg <= pwdata[OFFS_W-1:0];
            end
            else
            begin
                out_length_reg <= pwdata[OLEN_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_WINDOW_OFFSET)
        begin
            prdata = {{(32-OFFS_W){1'b0}}, window_offset_reg};
        end
        else
        begin
            prdata = {{(32-OLEN_W){1'b0}}, out_length_reg};
        end
    end

    // Effective window length, capped at memory depth
    logic [LEN_W-1:0] eff_len;
    assign eff_len = (32'(out_length_reg) > 32'(MAX_OUT_LEN)) ? LEN_W'(MAX_OUT_LEN)
                                                              : LEN_W'(out_length_reg);

    // Control state
    logic [2:0]       state_reg, state_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic             walk_rd_reg;
    acc_t             peak_reg;

    // Pipeline registers
    logic          a_valid_reg, a_rd_reg, a_inwin_reg;
    logic [AW-1:0] a_addr_reg;
    prod_t         a_prod_reg;
    logic          b_valid_reg, b_rd_reg, b_inwin_reg;
    logic [AW-1:0] b_addr_reg;
    prod_t         b_prod_reg;
    logic          fw_valid_reg;
    logic [AW-1:0] fw_addr_reg;
    acc_t          fw_data_reg;

    logic            out_valid_reg;
    acc_t            out_value_reg;
    logic            out_peak_reg;

    // Memory ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    acc_t          ram_wdata;
    logic [ACC_W-1:0] ram_rdata;

    // Pipe advances unless a read result is blocked by a full output register
    logic adv;
    logic in_acc;
    assign adv      = !(b_valid_reg && b_rd_reg && out_valid_reg && !m_tready);
    assign s_tready = (state_reg == ST_RUN) && adv;
    assign in_acc   = s_tvalid && s_tready;

    // Input word decode
    logic [OP_W-1:0]            in_op;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic signed [WEIGHT_W-1:0] in_weight;
    logic signed [START_W-1:0]  in_start;
    logic [INDEX_W-1:0]         in_index;
    logic [OPOS_W-1:0]          in_opos;
    logic signed [POS_W-1:0]    in_pos;
    logic                       pos_inwin, rd_inwin;
    logic [31:0]                opos_ext;

    assign in_op     = s_tuser;
    assign in_sample = s_tdata[23:0];
    assign in_weight = s_tdata[39:24];
    assign in_start  = s_tdata[63:40];
    assign in_index  = s_tdata[79:64];
    assign in_opos   = s_tdata[91:80];

    assign in_pos = {{(POS_W-START_W){in_start[START_W-1]}}, in_start}
                  - {{(POS_W-OFFS_W){window_offset_reg[OFFS_W-1]}}, window_offset_reg}
                  + {{(POS_W-INDEX_W){1'b0}}, in_index};
    assign pos_inwin = !in_pos[POS_W-1] && (32'(in_pos[POS_W-2:0]) < 32'(eff_len));
    assign opos_ext  = 32'(in_opos);
    assign rd_inwin  = opos_ext < 32'(eff_len);

    // Stage A: position check, product; memory read issued from this stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_acc && ((in_op == OP_ACC) || (in_op == OP_READ));
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_rd_reg    <= (in_op == OP_READ);
            a_inwin_reg <= (in_op == OP_READ) ? rd_inwin : pos_inwin;
            a_addr_reg  <= (in_op == OP_READ) ? opos_ext[AW-1:0] : in_pos[AW-1:0];
            a_prod_reg  <= in_sample * in_weight;
            b_rd_reg    <= a_rd_reg;
            b_inwin_reg <= a_inwin_reg;
            b_addr_reg  <= a_addr_reg;
            b_prod_reg  <= a_prod_reg;
        end
    end

    // Stage B: forwarded old value, saturating add or clear, write back
    acc_t               b_old;
    logic [ACC_W:0]     b_sum;
    acc_t               b_sat;
    logic               b_we;
    acc_t               b_wdata;

    assign b_old = (fw_valid_reg && (fw_addr_reg == b_addr_reg)) ? fw_data_reg : ram_rdata;
    assign b_sum = {b_old[ACC_W-1], b_old}
                 + {{(ACC_W+1-PROD_W){b_prod_reg[PROD_W-1]}}, b_prod_reg};
    always_comb
    begin
        if (b_sum[ACC_W] == b_sum[ACC_W-1])
        begin
            b_sat = b_sum[ACC_W-1:0];
        end
        else if (b_sum[ACC_W])
        begin
            b_sat = ACC_MIN;
        end
        else
        begin
            b_sat = ACC_MAX;
        end
    end
    assign b_we    = b_valid_reg && b_inwin_reg;
    assign b_wdata = b_rd_reg ? '0 : b_sat;

    // Forwarding register: last write, seen by the item that read alongside it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            fw_valid_reg <= b_we;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fw_addr_reg <= b_addr_reg;
            fw_data_reg <= b_wdata;
        end
    end

    // Memory port mux; a stalled stage B keeps re-reading its own entry
    logic walk_go;
    assign walk_go = (state_reg == ST_WALK) && (cnt_reg < eff_len);

    always_comb
    begin
        ram_we    = adv && b_we;
        ram_waddr = b_addr_reg;
        ram_wdata = b_wdata;
        ram_raddr = adv ? a_addr_reg : b_addr_reg;
        if (state_reg == ST_CLR)
        begin
            ram_we    = 1'b1;
            ram_waddr = cnt_reg[AW-1:0];
            ram_wdata = '0;
        end
        else if (walk_go)
        begin
            ram_we    = 1'b1;
            ram_waddr = cnt_reg[AW-1:0];
            ram_wdata = '0;
            ram_raddr = cnt_reg[AW-1:0];
        end
    end

    wdas_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MAX_OUT_LEN)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer: clearing pass, run, drain, window walk, peak emit
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_CLR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LEN_W'(MAX_OUT_LEN - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (in_acc && (in_op == OP_REDUCE))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cnt_next = '0;
                if (!a_valid_reg && !b_valid_reg)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_go)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLR;
            cnt_reg     <= '0;
            walk_rd_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            walk_rd_reg <= walk_go;
        end
    end

    // Running peak, floored at zero by its start value
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DRAIN)
        begin
            peak_reg <= '0;
        end
        else if (walk_rd_reg && ($signed(ram_rdata) > peak_reg))
        begin
            peak_reg <= ram_rdata;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((adv && b_valid_reg && b_rd_reg)
                 || ((state_reg == ST_EMIT) && (!out_valid_reg || m_tready)))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && b_valid_reg && b_rd_reg)
        begin
            out_value_reg <= b_inwin_reg ? b_old : '0;
            out_peak_reg  <= 1'b0;
        end
        else if ((state_reg == ST_EMIT) && (!out_valid_reg || m_tready))
        begin
            out_value_reg <= peak_reg;
            out_peak_reg  <= 1'b1;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_value_reg;
    assign m_tuser[0] = out_peak_reg;

    // Checks
    logic pipe_idle;
    logic rd_to_out;
    assign pipe_idle = !a_valid_reg && !b_valid_reg;
    assign rd_to_out = adv && b_valid_reg && b_rd_reg;

    `ASSERT_IMPLIES(a_clr_pipe_empty, clk, rst_n, state_reg == ST_CLR, pipe_idle)
    `ASSERT_IMPLIES(a_walk_pipe_empty, clk, rst_n, state_reg == ST_WALK, pipe_idle && !fw_valid_reg)
    `ASSERT_NEXT(a_read_lands, clk, rst_n, rd_to_out, out_valid_reg && !out_peak_reg)
    `ASSERT_IMPLIES(a_peak_nonneg, clk, rst_n, out_valid_reg && out_peak_reg, !out_value_reg[ACC_W-1])

endmodule

[test/weighted_delay_and_sum_stack_test.sv]
module weighted_delay_and_sum_stack_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wdas_pkg::*;

    localparam int STACK_DEPTH = 4096;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 1950;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int SAT_WORDS = 560;
    localparam int HOT_SPAN = 16;

    // Beam stack predictor and result checker
    class beam_scoreboard;
        acc_t stack_mem [STACK_DEPTH];
        logic signed [OFFS_W-1:0] win_offset;
        logic [OLEN_W-1:0] win_length;
        acc_t expected_value [$];
        logic expected_peak [$];
        int errors;

        function new();
            foreach (stack_mem[i])
                stack_mem[i] = '0;
            win_offset = '0;
            win_length = OUT_LENGTH_RST;
            errors = 0;
        endfunction

        function int window_len();
            return (win_length > STACK_DEPTH) ? STACK_DEPTH : int'(win_length);
        endfunction

        function int pending();
            return expected_value.size();
        endfunction

        function void set_register(logic reg_idx, logic [31:0] value);
            if (reg_idx == REG_WINDOW_OFFSET)
                win_offset = value[OFFS_W-1:0];
            else
                win_length = value[OLEN_W-1:0];
        endfunction

        // Apply one accepted input word, queue the result it causes
        function void note_word(logic [OP_W-1:0] op,
                                logic signed [SAMPLE_W-1:0] sample,
                                logic signed [WEIGHT_W-1:0] weight,
                                logic signed [START_W-1:0] start,
                                logic [INDEX_W-1:0] index,
                                logic [OPOS_W-1:0] opos);
            longint pos;
            longint sum;
            int len;
            len = window_len();
            case (op)
                OP_ACC:
                begin
                    pos = longint'(start) - longint'(win_offset) + longint'(index);
                    if (pos >= 0 && pos < len)
                    begin
                        sum = longint'(stack_mem[pos]) + longint'(sample) * longint'(weight);
                        if (sum > longint'(ACC_MAX))
                            sum = longint'(ACC_MAX);
                        else if (sum < longint'(ACC_MIN))
                            sum = longint'(ACC_MIN);
                        stack_mem[pos] = acc_t'(sum);
                    end
                end
                OP_READ:
                begin
                    sum = 0;
                    if (opos < len)
                    begin
                        sum = longint'(stack_mem[opos]);
                        stack_mem[opos] = '0;
                    end
                    expected_value.push_back(acc_t'(sum));
                    expected_peak.push_back(1'b0);
                end
                OP_REDUCE:
                begin
                    // peak is floored at zero
                    sum = 0;
                    for (int i = 0; i < len; i++)
                    begin
                        if (longint'(stack_mem[i]) > sum)
                            sum = longint'(stack_mem[i]);
                        stack_mem[i] = '0;
                    end
                    expected_value.push_back(acc_t'(sum));
                    expected_peak.push_back(1'b1);
                end
                default:
                    ;
            endcase
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] value, logic peak_flag);
            acc_t want_value;
            logic want_peak;
            if (expected_value.size() == 0)
            begin
                $error("unexpected result word: result_value %0d is_peak %0b",
                       $signed(value), peak_flag);
                errors++;
                return;
            end
            want_value = expected_value.pop_front();
            want_peak = expected_peak.pop_front();
            if (value !== want_value)
            begin
                $error("result_value: expected %0d, got %0d", want_value, $signed(value));
                errors++;
            end
            if (peak_flag !== want_peak)
            begin
                $error("is_peak: expected %0b, got %0b", want_peak, peak_flag);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    logic s_tvalid = 1'b0;
    logic s_tready;
    // sample_value, weight, trace_start, sample_index, out_position, zero pad
    logic [IN_DATA_W-1:0] s_tdata = '0;
    // opcode
    logic [OP_W-1:0] s_tuser = '0;

    logic m_tvalid;
    logic m_tready = 1'b0;
    // result_value
    logic [OUT_DATA_W-1:0] m_tdata;
    // is_peak
    logic [0:0] m_tuser;

    beam_scoreboard sb;
    bit calm = 1'b0;
    bit hold_off_req = 1'b0;
    int n_items = 0;
    int cycles = 0;

    weighted_delay_and_sum_stack dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("weighted_delay_and_sum_stack_test: FAIL");
        $finish;
    end

    // Result side: random stalls, a long hold-off on request, calm stretches
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= calm || ($urandom_range(99) >= 26);
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser[0]);
    end

    // Offer one input word, return at the edge where it is taken
    task automatic send_word(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] sample,
                             logic [WEIGHT_W-1:0] weight, logic [START_W-1:0] start,
                             logic [INDEX_W-1:0] index, logic [OPOS_W-1:0] opos);
        while (!calm && $urandom_range(99) < 26)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {4'b0, opos, index, start, weight, sample};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_word(op, sample, weight, start, index, opos);
        if (op != OP_UNUSED)
            n_items++;
    endtask

    // Register write followed by a read-back
    task automatic write_reg(logic reg_idx, logic [31:0] value);
        logic [31:0] mask;
        mask = (reg_idx == REG_WINDOW_OFFSET) ? 32'h00FF_FFFF : 32'h0000_1FFF;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_register(reg_idx, value);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if ((prdata & mask) !== (value & mask))
        begin
            $error("register %0d: expected %0h, got %0h", reg_idx, value & mask,
                   prdata & mask);
            sb.errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid, wait for every expected word, then let the pipe go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return WEIGHT_W'($urandom);
        endcase
    endfunction

    // Half the picks land in a few hot entries so that sums build up
    function automatic int pick_position(int len);
        if (len <= 0)
            return 0;
        if ($urandom_range(1) == 0)
            return $urandom_range(((len < HOT_SPAN) ? len : HOT_SPAN) - 1);
        return $urandom_range(len - 1);
    endfunction

    // Accumulate word aimed at a window position, with a random split of start and index
    task automatic send_hit(int pos, logic [SAMPLE_W-1:0] sample, logic [WEIGHT_W-1:0] weight);
        longint base;
        longint lo;
        longint hi;
        longint idx;
        longint start;
        base = longint'(sb.win_offset) + pos;
        lo = base - 8388607;
        hi = base + 8388608;
        if (lo < 0)
            lo = 0;
        if (hi > 65535)
            hi = 65535;
        idx = $urandom_range(int'(hi), int'(lo));
        start = base - idx;
        send_word(OP_ACC, sample, weight, start[START_W-1:0], idx[INDEX_W-1:0],
                  OPOS_W'($urandom));
    endtask

    task automatic send_random_word(bit read_heavy);
        int r;
        int len;
        logic [OPOS_W-1:0] opos;
        r = $urandom_range(99);
        len = sb.window_len();
        if (r < (read_heavy ? 30 : 62) && len > 0)
            send_hit(pick_position(len), pick_sample(), pick_weight());
        else if (r < (read_heavy ? 36 : 70))
            send_word(OP_ACC, SAMPLE_W'($urandom), WEIGHT_W'($urandom), START_W'($urandom),
                      INDEX_W'($urandom), OPOS_W'($urandom));
        else if (r < 93)
        begin
            opos = (len > 0 && $urandom_range(3) != 0) ? OPOS_W'(pick_position(len))
                                                       : OPOS_W'($urandom);
            send_word(OP_READ, SAMPLE_W'($urandom), WEIGHT_W'($urandom), START_W'($urandom),
                      INDEX_W'($urandom), opos);
        end
        else if (r < 96)
            send_word(OP_REDUCE, SAMPLE_W'($urandom), WEIGHT_W'($urandom),
                      START_W'($urandom), INDEX_W'($urandom), OPOS_W'($urandom));
        else
            send_word(OP_UNUSED, SAMPLE_W'($urandom), WEIGHT_W'($urandom),
                      START_W'($urandom), INDEX_W'($urandom), OPOS_W'($urandom));
    endtask

    // Drive one entry past the 48-bit limit in one direction, then read it out
    task automatic saturate(bit upward);
        for (int k = 0; k < SAT_WORDS; k++)
        begin
            if (upward)
            begin
                if ($urandom_range(1))
                    send_hit(0, 24'h800000, 16'h8000);
                else
                    send_hit(0, 24'h7FFFFF, 16'h7FFF);
            end
            else
            begin
                if ($urandom_range(1))
                    send_hit(0, 24'h800000, 16'h7FFF);
                else
                    send_hit(0, 24'h7FFFFF, 16'h8000);
            end
        end
        send_word(OP_READ, SAMPLE_W'($urandom), WEIGHT_W'($urandom), START_W'($urandom),
                  INDEX_W'($urandom), '0);
        send_word(OP_REDUCE, SAMPLE_W'($urandom), WEIGHT_W'($urandom), START_W'($urandom),
                  INDEX_W'($urandom), OPOS_W'($urandom));
    endtask

    initial
    begin
        int phase;
        int count;
        logic [OFFS_W-1:0] offs;
        logic [OLEN_W-1:0] olen;

        sb = new();
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: default window, extremes, misses on both sides, read twice, unused opcode
        send_word(OP_ACC, 24'h7FFFFF, 16'h7FFF, 24'd0, 16'd0, 12'd0);
        send_word(OP_ACC, 24'h800000, 16'h8000, 24'd0, 16'd0, 12'd0);
        send_word(OP_ACC, 24'h800000, 16'h7FFF, 24'h800000, 16'hFFFF, 12'd0);
        send_word(OP_ACC, 24'h7FFFFF, 16'h8000, 24'h7FFFFF, 16'hFFFF, 12'd0);
        send_word(OP_ACC, 24'd1, -16'sd1, 24'd4095, 16'd0, 12'd0);
        send_word(OP_ACC, 24'd12345, 16'd16384, -24'sd65525, 16'hFFFF, 12'd0);
        send_word(OP_ACC, -24'sd5, 16'd3, 24'd3, 16'd0, 12'd0);
        send_word(OP_READ, '0, '0, '0, '0, 12'd0);
        send_word(OP_READ, '0, '0, '0, '0, 12'd0);
        send_word(OP_READ, '0, '0, '0, '0, 12'd4095);
        send_word(OP_UNUSED, '1, '1, '1, '1, '1);
        send_word(OP_ACC, 24'd7, 16'd9, 24'd100, 16'd0, 12'd0);
        settle();

        // Short window: reduce of negatives only gives zero; entries beyond are kept
        write_reg(REG_OUT_LENGTH, 32'd8);
        send_word(OP_REDUCE, '0, '0, '0, '0, '0);
        send_word(OP_READ, '0, '0, '0, '0, 12'd10);
        settle();

        // Length above the memory size
        write_reg(REG_OUT_LENGTH, 32'd8191);
        send_word(OP_READ, '0, '0, '0, '0, 12'd10);
        send_word(OP_REDUCE, '0, '0, '0, '0, '0);
        settle();

        // Empty window
        write_reg(REG_WINDOW_OFFSET, 32'hFF80_0000);
        write_reg(REG_OUT_LENGTH, 32'd0);
        send_word(OP_ACC, 24'd100, 16'd100, 24'h800000, 16'd0, 12'd0);
        send_word(OP_READ, '0, '0, '0, '0, 12'd0);
        send_word(OP_REDUCE, '0, '0, '0, '0, '0);
        settle();

        // One-entry window at the top offset, read past the window
        write_reg(REG_WINDOW_OFFSET, 32'h007F_FFFF);
        write_reg(REG_OUT_LENGTH, 32'd1);
        send_word(OP_ACC, 24'h800000, 16'h8000, 24'h7FFFFF, 16'd0, 12'd0);
        send_word(OP_ACC, 24'd77, 16'd77, 24'h7FFFFF, 16'd1, 12'd0);
        send_word(OP_READ, '0, '0, '0, '0, 12'd4095);
        send_word(OP_REDUCE, '0, '0, '0, '0, '0);
        send_word(OP_READ, '0, '0, '0, '0, 12'd0);

        // Random phases, each with its own window
        phase = 0;
        while (n_items < ITEM_TARGET)
        begin
            settle();
            calm = 1'b0;
            case ($urandom_range(9))
                0: offs = 24'h800000;
                1: offs = 24'h7FFFFF;
                2: offs = '0;
                default: offs = OFFS_W'($urandom);
            endcase
            if (phase == 1 || phase == 4)
                olen = 13'd1;
            else
            begin
                case ($urandom_range(9))
                    0: olen = 13'd0;
                    1: olen = 13'd1;
                    2: olen = 13'd4096;
                    3: olen = 13'd8191;
                    4: olen = OLEN_W'($urandom);
                    default: olen = OLEN_W'($urandom_range(64, 1));
                endcase
            end
            write_reg(REG_WINDOW_OFFSET, {{8{offs[OFFS_W-1]}}, offs});
            write_reg(REG_OUT_LENGTH, {19'd0, olen});

            if (phase == 1 || phase == 4)
                saturate(phase == 1);
            else
            begin
                calm = (phase == 3);
                // receiver backs off while reads keep coming
                if (phase == 2)
                    hold_off_req = 1'b1;
                count = $urandom_range(120, 40);
                repeat (count)
                    send_random_word(phase == 2);
            end
            phase++;
        end
        settle();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("weighted_delay_and_sum_stack_test: PASS");
        else
            $display("weighted_delay_and_sum_stack_test: FAIL");
        $finish;
    end

endmodule
